// ===== hdl/rgb_overlay_alpha_compositor_defines.svh =====
// ----------------------------------------------------------------------------
// RGB overlay compositor assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RGB_OVERLAY_ALPHA_COMPOSITOR_DEFINES_SVH
`define RGB_OVERLAY_ALPHA_COMPOSITOR_DEFINES_SVH

// same-cycle implication
`define RGBOAC_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBOAC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rgboac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB overlay compositor package
// Beat types, register indexes and format constants.
// ----------------------------------------------------------------------------
package rgboac_pkg;

  localparam int unsigned FMT_FOUR_BIT = 0;
  localparam int unsigned FMT_BGR_BIT  = 1;

  localparam logic [7:0] BYTE_MAX = 8'd255;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0]  BG_FMT_RST    = 2'd0;
  localparam logic [1:0]  OV_FMT_RST    = 2'd1;
  localparam logic [12:0] FRAME_W_RST   = 13'd640;
  localparam logic [12:0] FRAME_H_RST   = 13'd480;
  localparam logic [12:0] OV_W_RST      = 13'd64;
  localparam logic [12:0] OV_H_RST      = 13'd64;
  localparam logic [11:0] OFFSET_X_RST  = 12'd0;
  localparam logic [11:0] OFFSET_Y_RST  = 12'd0;

  typedef enum logic [2:0] {
    REG_BG_FORMAT = 3'd0,
    REG_OV_FORMAT = 3'd1,
    REG_FRAME_W   = 3'd2,
    REG_FRAME_H   = 3'd3,
    REG_OV_W      = 3'd4,
    REG_OV_H      = 3'd5,
    REG_OFFSET_X  = 3'd6,
    REG_OFFSET_Y  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    cfg_idx_e    reg_idx;
    logic [12:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0] bg_byte0;
    logic [7:0] bg_byte1;
    logic [7:0] bg_byte2;
    logic [7:0] bg_byte3;
    logic [7:0] ov_byte0;
    logic [7:0] ov_byte1;
    logic [7:0] ov_byte2;
    logic [7:0] ov_byte3;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic       inside_window;
    logic       line_end;
    logic       frame_end;
  } pix_out_t;

  typedef struct packed {
    logic in_window;
    logic line_end;
    logic frame_end;
  } tag_t;

  // per byte: out = floor((x*(255-a) + y*a) / 255)
  typedef struct packed {
    logic [3:0][7:0] x;
    logic [3:0][7:0] y;
    logic [3:0][7:0] a;
    tag_t            tag;
  } job_t;

endpackage

// ===== hdl/rgboac_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB overlay compositor stream interface
// Valid/ready channel carrying one beat of a given payload type.
// ----------------------------------------------------------------------------
interface rgboac_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rgb_overlay_alpha_compositor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB overlay alpha compositor
// Places an overlay window over a raster background stream and blends or
// replaces the covered pixels.
// ----------------------------------------------------------------------------
// Takes one background pixel with its overlay pixel per clock and returns one
// output pixel per clock while pix_out_o is ready; an accepted pixel passes the
// queue and then the two-register blend pipeline (weighted sum, then the divide
// by 255). A two-beat queue sits between the classifier and that pipeline, so
// input keeps flowing while the output stalls, until the queue fills.
// Write the configuration registers only between frames with nothing in flight.
module rgb_overlay_alpha_compositor
  import rgboac_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rgboac_stream_if.sink   cfg_i,
  rgboac_stream_if.sink   pix_in_i,
  rgboac_stream_if.source pix_out_o
);

`include "rgb_overlay_alpha_compositor_defines.svh"

  rgboac_stream_if #(.T(job_t)) job_wr ();
  rgboac_stream_if #(.T(job_t)) job_rd ();

  rgboac_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .pix    (pix_in_i),
    .job    (job_wr)
  );

  rgboac_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr     (job_wr),
    .rd     (job_rd)
  );

  rgboac_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job    (job_rd),
    .pix    (pix_out_o)
  );

`RGBOAC_ASSERT_IMPLY(a_frame_end_ends_line, clk_i, rst_ni, pix_out_o.valid && pix_out_o.data.frame_end, pix_out_o.data.line_end, "frame end without line end")
`RGBOAC_ASSERT_IMPLY(a_outside_no_weight, clk_i, rst_ni, job_wr.valid && !job_wr.data.tag.in_window, job_wr.data.a == '0, "outside pixel carries blend weight")
`RGBOAC_ASSERT_NEXT(a_queue_holds, clk_i, rst_ni, job_rd.valid && !job_rd.ready, job_rd.valid, "queue dropped a stalled job")

endmodule

// ===== hdl/rgboac_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB overlay compositor front end
// Holds configuration and position counters, classifies each pixel and
// turns it into per-byte blend operands.
// ----------------------------------------------------------------------------
module rgboac_front
  import rgboac_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rgboac_stream_if.sink   cfg,
  rgboac_stream_if.sink   pix,
  rgboac_stream_if.source job
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned XW = (CW + 1 > 14) ? CW + 1 : 14;
  localparam int unsigned YW = (RW + 1 > 14) ? RW + 1 : 14;

  logic [1:0]  bg_fmt_q, ov_fmt_q;
  logic [12:0] frame_w_q, frame_h_q, ov_w_q, ov_h_q;
  logic [11:0] offset_x_q, offset_y_q;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [XW-1:0] w_eff, col_ext;
  logic [YW-1:0] h_eff, row_ext;
  logic          in_x, in_y, in_win, lend, fend;
  logic          bg_four, ov_alpha, swap;
  logic [3:0][7:0] bg, ov;
  logic [2:0][7:0] colour;
  logic          pix_fire;
  job_t          job_d;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_fmt_q   <= BG_FMT_RST;
      ov_fmt_q   <= OV_FMT_RST;
      frame_w_q  <= FRAME_W_RST;
      frame_h_q  <= FRAME_H_RST;
      ov_w_q     <= OV_W_RST;
      ov_h_q     <= OV_H_RST;
      offset_x_q <= OFFSET_X_RST;
      offset_y_q <= OFFSET_Y_RST;
    end else if (cfg.valid) begin
      case (cfg.data.reg_idx)
        REG_BG_FORMAT: bg_fmt_q   <= cfg.data.wdata[1:0];
        REG_OV_FORMAT: ov_fmt_q   <= cfg.data.wdata[1:0];
        REG_FRAME_W:   frame_w_q  <= cfg.data.wdata;
        REG_FRAME_H:   frame_h_q  <= cfg.data.wdata;
        REG_OV_W:      ov_w_q     <= cfg.data.wdata;
        REG_OV_H:      ov_h_q     <= cfg.data.wdata;
        REG_OFFSET_X:  offset_x_q <= cfg.data.wdata[11:0];
        REG_OFFSET_Y:  offset_y_q <= cfg.data.wdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_w_q == '0) begin
      w_eff = XW'(1);
    end else if (XW'(frame_w_q) > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(frame_w_q);
    end
    if (frame_h_q == '0) begin
      h_eff = YW'(1);
    end else if (YW'(frame_h_q) > YW'(MAX_HEIGHT)) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = YW'(frame_h_q);
    end
  end

  assign col_ext = XW'(col_q);
  assign row_ext = YW'(row_q);
  assign in_x = (col_ext >= XW'(offset_x_q)) &&
                (col_ext < XW'(offset_x_q) + XW'(ov_w_q));
  assign in_y = (row_ext >= YW'(offset_y_q)) &&
                (row_ext < YW'(offset_y_q) + YW'(ov_h_q));
  assign in_win = in_x && in_y;
  assign lend = (col_ext + XW'(1)) >= w_eff;
  assign fend = lend && ((row_ext + YW'(1)) >= h_eff);

  assign bg_four  = bg_fmt_q[FMT_FOUR_BIT];
  assign ov_alpha = ov_fmt_q[FMT_FOUR_BIT];
  assign swap     = bg_fmt_q[FMT_BGR_BIT] ^ ov_fmt_q[FMT_BGR_BIT];

  assign bg = {pix.data.bg_byte3, pix.data.bg_byte2, pix.data.bg_byte1, pix.data.bg_byte0};
  assign ov = {pix.data.ov_byte3, pix.data.ov_byte2, pix.data.ov_byte1, pix.data.ov_byte0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      colour[i] = swap ? ov[2 - i] : ov[i];
    end
  end

  always_comb begin
    job_d.tag.in_window = in_win;
    job_d.tag.line_end  = lend;
    job_d.tag.frame_end = fend;
    for (int i = 0; i < 3; i++) begin
      job_d.x[i] = bg[i];
      job_d.y[i] = colour[i];
      job_d.a[i] = !in_win ? 8'd0 : (ov_alpha ? ov[3] : BYTE_MAX);
    end
    job_d.y[3] = BYTE_MAX;
    if (!in_win) begin
      job_d.x[3] = bg_four ? bg[3] : (ov_alpha ? BYTE_MAX : 8'd0);
      job_d.a[3] = 8'd0;
    end else if (ov_alpha) begin
      job_d.x[3] = bg_four ? bg[3] : BYTE_MAX;
      job_d.a[3] = bg_four ? ov[3] : 8'd0;
    end else begin
      job_d.x[3] = bg_four ? BYTE_MAX : 8'd0;
      job_d.a[3] = 8'd0;
    end
  end

  assign job.valid = pix.valid;
  assign job.data  = job_d;
  assign pix.ready = job.ready;
  assign pix_fire  = pix.valid && job.ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_fire) begin
      if (lend) begin
        col_d = '0;
        row_d = fend ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== hdl/rgboac_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB overlay compositor job queue
// Short FIFO between the classifier and the blend pipeline.
// ----------------------------------------------------------------------------
module rgboac_queue
  import rgboac_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  rgboac_stream_if.sink   wr,
  rgboac_stream_if.source rd
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  job_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          push, pop;

  assign wr.ready = (cnt_q != (PW + 1)'(QUEUE_DEPTH));
  assign rd.valid = (cnt_q != '0);
  assign rd.data  = mem_q[rd_ptr_q];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PW + 1)'(push) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== hdl/rgboac_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB overlay compositor blend pipeline
// Weighted sum per byte, then exact floor division by 255 into the output
// register.
// ----------------------------------------------------------------------------
module rgboac_back
  import rgboac_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  rgboac_stream_if.sink   job,
  rgboac_stream_if.source pix
);

  logic             valid1_q, valid2_q;
  logic             adv1, adv2;
  logic [3:0][15:0] sum_q, sum_d;
  tag_t             tag1_q;
  logic [3:0][7:0]  res;
  pix_out_t         out_q, out_d;

  function automatic logic [7:0] div255(input logic [15:0] s);
    logic [16:0] q;
    q = 17'(s) + 17'(s[15:8]) + 17'd1;
    return q[15:8];
  endfunction

  assign adv2      = !valid2_q || pix.ready;
  assign adv1      = !valid1_q || adv2;
  assign job.ready = adv1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_d[i] = 16'(job.data.x[i] * (BYTE_MAX - job.data.a[i])) +
                 16'(job.data.y[i] * job.data.a[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res[i] = div255(sum_q[i]);
    end
    out_d.out_byte0     = res[0];
    out_d.out_byte1     = res[1];
    out_d.out_byte2     = res[2];
    out_d.out_byte3     = res[3];
    out_d.inside_window = tag1_q.in_window;
    out_d.line_end      = tag1_q.line_end;
    out_d.frame_end     = tag1_q.frame_end;
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      sum_q  <= sum_d;
      tag1_q <= job.data.tag;
    end
    if (adv2) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      if (adv1) begin
        valid1_q <= job.valid;
      end
      if (adv2) begin
        valid2_q <= valid1_q;
      end
    end
  end

  assign pix.valid = valid2_q;
  assign pix.data  = out_q;

endmodule
